### rtl/core/bti_pkg.sv
package bti_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int BANK_DEPTH  = (MAX_ROWS * MAX_COLS) / 4;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_P_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_T_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_INV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T_INV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd5;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_VALUE   = 2'd1,
        OP_SLOPE_P = 2'd2,
        OP_SLOPE_T = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ROW_W-1:0]   row_index;
        logic [COL_W-1:0]   col_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] pressure;
        logic signed [31:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               pressure_out_of_range;
        logic               temperature_out_of_range;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] p_origin;
        logic signed [31:0] t_origin;
        logic [31:0]        p_inv;
        logic [31:0]        t_inv;
        logic [ROW_W-1:0]   row_last;
        logic [COL_W-1:0]   col_last;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic signed [31:0] value;
        logic [15:0]        lp;
        logic [15:0]        lt;
        logic               pbad;
        logic               tbad;
    } q_item_t;

endpackage

### rtl/core/bti_front.sv
module bti_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  bti_pkg::in_item_t s_item,
    input  logic              s_valid,
    output logic              s_ready,
    input  bti_pkg::cfg_t     cfg,
    output logic              q_push,
    output bti_pkg::q_item_t  q_data,
    input  logic              q_full
);
    import bti_pkg::*;

    logic               advance;
    logic               a_valid_reg;
    in_item_t           a_item_reg;
    logic signed [32:0] a_dp_reg;
    logic signed [32:0] a_dt_reg;
    logic               b_valid_reg;
    in_item_t           b_item_reg;
    logic               b_pneg_reg;
    logic               b_tneg_reg;
    logic [63:0]        b_ppos_reg;
    logic [63:0]        b_tpos_reg;
    logic [31:0]        p_idx;
    logic [31:0]        t_idx;

    assign advance = !(b_valid_reg && q_full);
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
        if (advance) begin
            a_item_reg <= s_item;
            a_dp_reg   <= {s_item.pressure[31], s_item.pressure}
                          - {cfg.p_origin[31], cfg.p_origin};
            a_dt_reg   <= {s_item.temperature[31], s_item.temperature}
                          - {cfg.t_origin[31], cfg.t_origin};
            b_item_reg <= a_item_reg;
            b_pneg_reg <= a_dp_reg[32];
            b_tneg_reg <= a_dt_reg[32];
            b_ppos_reg <= 64'(a_dp_reg[31:0]) * 64'(cfg.p_inv);
            b_tpos_reg <= 64'(a_dt_reg[31:0]) * 64'(cfg.t_inv);
        end
    end

    assign p_idx = b_ppos_reg[63:32];
    assign t_idx = b_tpos_reg[63:32];

    always_comb begin
        q_push       = b_valid_reg && !q_full;
        q_data.op    = b_item_reg.op;
        q_data.row   = b_item_reg.row_index;
        q_data.col   = b_item_reg.col_index;
        q_data.value = b_item_reg.entry_value;
        q_data.pbad  = b_pneg_reg ? (cfg.p_inv != 32'd0) : (p_idx > 32'(cfg.row_last));
        q_data.tbad  = b_tneg_reg ? (cfg.t_inv != 32'd0) : (t_idx > 32'(cfg.col_last));
        q_data.lp    = b_pneg_reg ? 16'd0 : b_ppos_reg[31:16];
        q_data.lt    = b_tneg_reg ? 16'd0 : b_tpos_reg[31:16];
        if (b_item_reg.op != OP_WRITE) begin
            q_data.row = (b_pneg_reg || q_data.pbad) ? '0 : p_idx[ROW_W-1:0];
            q_data.col = (b_tneg_reg || q_data.tbad) ? '0 : t_idx[COL_W-1:0];
        end
    end

endmodule

### rtl/core/bti_queue.sv
module bti_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  bti_pkg::q_item_t din,
    output logic             full,
    input  logic             pop,
    output bti_pkg::q_item_t dout,
    output logic             empty
);
    import bti_pkg::*;

    q_item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
        if (push) slot_reg[wr_ptr_reg] <= din;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of bound");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count not incremented");

endmodule

### rtl/core/bti_back.sv
module bti_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bti_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  bti_pkg::q_item_t   q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output bti_pkg::out_item_t m_item
);
    import bti_pkg::*;

    logic signed [31:0] bank_mem [4][BANK_DEPTH];
    logic signed [31:0] rd_reg [4];
    logic [BANK_AW-1:0] rd_addr [4];

    logic               adv;
    logic               r_valid_reg;
    q_item_t            r_item_reg;
    logic               u_valid_reg;
    logic               u_pbad_reg;
    logic               u_tbad_reg;
    logic signed [49:0] u0_reg;
    logic signed [49:0] u1_reg;
    logic [15:0]        l2_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic               wr_en;
    logic [1:0]         wr_bank;
    logic [BANK_AW-1:0] wr_addr;

    logic signed [31:0] f00, f10, f01, f11;
    logic signed [32:0] diff0, diff1;
    logic signed [31:0] base0, base1;
    logic signed [32:0] mul;
    logic [15:0]        l2_next;
    logic signed [65:0] prod0, prod1;
    logic signed [49:0] u0_next, u1_next;
    logic signed [50:0] d2;
    logic signed [16:0] l2s;
    logic signed [67:0] prod2;
    logic signed [51:0] res;
    out_item_t          m_item_next;

    assign adv     = !m_valid_reg || m_ready;
    assign q_pop   = !q_empty && adv;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        for (int b = 0; b < 4; b++) begin
            row = (q_data.row[0] == b[1]) ? q_data.row : q_data.row + 1'b1;
            col = (q_data.col[0] == b[0]) ? q_data.col : q_data.col + 1'b1;
            rd_addr[b] = {row[ROW_W-1:1], col[COL_W-1:1]};
        end
    end

    assign wr_en   = q_pop && (q_data.op == OP_WRITE)
                     && (int'(q_data.row) < MAX_ROWS) && (int'(q_data.col) < MAX_COLS);
    assign wr_bank = {q_data.row[0], q_data.col[0]};
    assign wr_addr = {q_data.row[ROW_W-1:1], q_data.col[COL_W-1:1]};

    always_ff @(posedge aclk) begin
        if (wr_en) bank_mem[wr_bank][wr_addr] <= q_data.value;
        if (adv) begin
            for (int b = 0; b < 4; b++) begin
                rd_reg[b] <= bank_mem[b][rd_addr[b]];
            end
        end
    end

    always_comb begin
        f00 = rd_reg[{r_item_reg.row[0], r_item_reg.col[0]}];
        f10 = rd_reg[{~r_item_reg.row[0], r_item_reg.col[0]}];
        f01 = rd_reg[{r_item_reg.row[0], ~r_item_reg.col[0]}];
        f11 = rd_reg[{~r_item_reg.row[0], ~r_item_reg.col[0]}];
        base0   = '0;
        base1   = '0;
        l2_next = r_item_reg.lt;
        unique case (r_item_reg.op)
            OP_SLOPE_P: begin
                diff0 = {f10[31], f10} - {f00[31], f00};
                diff1 = {f11[31], f11} - {f01[31], f01};
                mul   = {1'b0, cfg.p_inv};
            end
            OP_SLOPE_T: begin
                diff0   = {f01[31], f01} - {f00[31], f00};
                diff1   = {f11[31], f11} - {f10[31], f10};
                mul     = {1'b0, cfg.t_inv};
                l2_next = r_item_reg.lp;
            end
            default: begin
                diff0 = {f10[31], f10} - {f00[31], f00};
                diff1 = {f11[31], f11} - {f01[31], f01};
                mul   = {17'd0, r_item_reg.lp};
                base0 = f00;
                base1 = f01;
            end
        endcase
        prod0   = diff0 * mul;
        prod1   = diff1 * mul;
        u0_next = {{18{base0[31]}}, base0} + prod0[65:16];
        u1_next = {{18{base1[31]}}, base1} + prod1[65:16];
    end

    always_comb begin
        d2    = {u1_reg[49], u1_reg} - {u0_reg[49], u0_reg};
        l2s   = {1'b0, l2_reg};
        prod2 = d2 * l2s;
        res   = {{2{u0_reg[49]}}, u0_reg} + prod2[67:16];
        m_item_next.pressure_out_of_range    = u_pbad_reg;
        m_item_next.temperature_out_of_range = u_tbad_reg;
        if (u_pbad_reg || u_tbad_reg) begin
            m_item_next.result_value = '0;
        end else if (res[51:31] != {21{res[51]}}) begin
            m_item_next.result_value = res[51] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            m_item_next.result_value = res[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            r_valid_reg <= q_pop && (q_data.op != OP_WRITE);
            u_valid_reg <= r_valid_reg;
            m_valid_reg <= u_valid_reg;
        end
        if (adv) begin
            r_item_reg <= q_data;
            u0_reg     <= u0_next;
            u1_reg     <= u1_next;
            l2_reg     <= l2_next;
            u_pbad_reg <= r_item_reg.pbad;
            u_tbad_reg <= r_item_reg.tbad;
            m_item_reg <= m_item_next;
        end
    end

    a_pop_only_when_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> adv) else $error("pop while back end stalled");
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_item_reg.pressure_out_of_range
                         || m_item_reg.temperature_out_of_range))
        |-> m_item_reg.result_value == 32'sd0) else $error("flagged result not zero");
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (u_valid_reg && !adv) |=> u_valid_reg) else $error("stalled stage lost item");

endmodule

### rtl/core/bilinear_table_interpolator_unit.sv
// Bilinear table interpolator, Q16.16, uniform grid of up to 16 x 16 points.
// Input channel s_valid/s_ready/s_item: op 0 stores entry_value at
// (row_index, col_index) and gives no result; ops 1..3 query the value,
// the slope along pressure or the slope along temperature at
// (pressure, temperature). Result channel m_valid/m_ready/m_item carries
// result_value and the two out-of-range flags, one transfer per query.
// Configuration: cfg_wr_en/cfg_index/cfg_data; the user must see that it
// is written only while idle, as the block does not enforce this.
// Throughput: one item per cycle while s_ready is high; four banks split by
// row and column parity let the four neighbors be read in the same cycle.
// The front end (offset, position multiply, range check) feeds a four-entry
// queue; the back end writes and reads the banks, interpolates and saturates.
// While m_valid is high and m_ready low the back end holds; items enter
// until the queue is full and stage b holds one, then s_ready drops.
// Reset restores the configuration defaults and empties all stages; table
// contents are undefined until written.
module bilinear_table_interpolator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bti_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bti_pkg::out_item_t                 m_item,
    input  logic                               cfg_wr_en,
    input  logic [bti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bti_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bti_pkg::*;

    logic signed [31:0] p_origin_reg;
    logic signed [31:0] t_origin_reg;
    logic [31:0]        p_inv_reg;
    logic [31:0]        t_inv_reg;
    logic [4:0]         rows_reg;
    logic [4:0]         cols_reg;
    cfg_t               cfg;

    logic    q_push, q_pop, q_full, q_empty;
    q_item_t q_din, q_dout;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_origin_reg <= '0;
            t_origin_reg <= '0;
            p_inv_reg    <= 32'd65536;
            t_inv_reg    <= 32'd65536;
            rows_reg     <= 5'(MAX_ROWS);
            cols_reg     <= 5'(MAX_COLS);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_P_ORIGIN: p_origin_reg <= cfg_data;
                CFG_T_ORIGIN: t_origin_reg <= cfg_data;
                CFG_P_INV:    p_inv_reg    <= cfg_data;
                CFG_T_INV:    t_inv_reg    <= cfg_data;
                CFG_ROWS:     rows_reg     <= cfg_data[4:0];
                CFG_COLS:     cols_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.p_origin = p_origin_reg;
        cfg.t_origin = t_origin_reg;
        cfg.p_inv    = p_inv_reg;
        cfg.t_inv    = t_inv_reg;
        if (rows_reg < 5'd2)                cfg.row_last = '0;
        else if (rows_reg > 5'(MAX_ROWS))   cfg.row_last = ROW_W'(MAX_ROWS - 2);
        else                                cfg.row_last = ROW_W'(rows_reg - 5'd2);
        if (cols_reg < 5'd2)                cfg.col_last = '0;
        else if (cols_reg > 5'(MAX_COLS))   cfg.col_last = COL_W'(MAX_COLS - 2);
        else                                cfg.col_last = COL_W'(cols_reg - 5'd2);
    end

    bti_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cfg     (cfg),
        .q_push  (q_push),
        .q_data  (q_din),
        .q_full  (q_full)
    );

    bti_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    bti_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_dout),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bti_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int CYCLE_LIMIT = 400000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;
    logic       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bilinear_table_interpolator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // shadow of the block's configuration and table
    logic signed [31:0] p_org, t_org;
    logic [31:0]        p_inv, t_inv;
    logic [4:0]         rows_n, cols_n;
    logic signed [31:0] grid [MAX_ROWS][MAX_COLS];

    out_item_t pending_results[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom % 100) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_item);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (want !== m_item) begin
                    $display({"%0t result mismatch: expected val %h pbad %b tbad %b,",
                              " got val %h pbad %b tbad %b"},
                             $time, want.result_value, want.pressure_out_of_range,
                             want.temperature_out_of_range, m_item.result_value,
                             m_item.pressure_out_of_range,
                             m_item.temperature_out_of_range);
                    mismatches++;
                end
            end
        end
    end

    function automatic int clamp_points(logic [4:0] n);
        if (n < 2) return 2;
        if (n > 16) return 16;
        return int'(n);
    endfunction

    function automatic void find_cell(input logic signed [31:0] c, o, input logic [31:0] inv,
                                      input int cnt, output bit bad, output int idx,
                                      output logic [15:0] fr);
        longint d;
        logic [63:0] pos;
        d = longint'(c) - longint'(o);
        idx = 0;
        fr = '0;
        bad = 1'b0;
        if (d < 0) begin
            bad = (inv != 0);
        end else begin
            pos = 64'(d) * 64'(inv);
            if (pos[63:32] > 32'(cnt - 2)) begin
                bad = 1'b1;
            end else begin
                idx = int'(pos[63:32]);
                fr = pos[31:16];
            end
        end
    endfunction

    function automatic wide_t blend(wide_t a, wide_t b, logic [15:0] l);
        wide_t p;
        p = (b - a) * $signed({112'd0, l});
        return a + (p >>> 16);
    endfunction

    function automatic wide_t scale_by(wide_t d, logic [31:0] inv);
        wide_t p;
        p = d * $signed({96'd0, inv});
        return p >>> 16;
    endfunction

    function automatic out_item_t interpolate(in_item_t it);
        out_item_t o;
        bit pb, tb_bad;
        int ip, it_idx;
        logic [15:0] lp, lt;
        wide_t f00, f10, f01, f11, res;
        find_cell(it.pressure, p_org, p_inv, clamp_points(rows_n), pb, ip, lp);
        find_cell(it.temperature, t_org, t_inv, clamp_points(cols_n), tb_bad, it_idx, lt);
        res = 0;
        if (!pb && !tb_bad) begin
            f00 = grid[ip][it_idx];
            f10 = grid[ip + 1][it_idx];
            f01 = grid[ip][it_idx + 1];
            f11 = grid[ip + 1][it_idx + 1];
            case (it.op)
                OP_VALUE: res = blend(blend(f00, f10, lp), blend(f01, f11, lp), lt);
                OP_SLOPE_P: res = blend(scale_by(f10 - f00, p_inv),
                                        scale_by(f11 - f01, p_inv), lt);
                default: res = blend(scale_by(f01 - f00, t_inv),
                                     scale_by(f11 - f10, t_inv), lp);
            endcase
            if (res > wide_t'(32'sh7FFFFFFF)) res = wide_t'(32'sh7FFFFFFF);
            if (res < wide_t'(-64'sd2147483648)) res = wide_t'(-64'sd2147483648);
        end
        o.result_value = res[31:0];
        o.pressure_out_of_range = pb;
        o.temperature_out_of_range = tb_bad;
        return o;
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge aclk);
        while (($urandom % 100) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item = it;
        do @(posedge aclk); while (!s_ready);
        if (it.op == OP_WRITE)
            grid[it.row_index][it.col_index] = it.entry_value;
        else
            pending_results.push_back(interpolate(it));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_P_ORIGIN: p_org = val;
            CFG_T_ORIGIN: t_org = val;
            CFG_P_INV:    p_inv = val;
            CFG_T_INV:    t_inv = val;
            CFG_ROWS:     rows_n = val[4:0];
            CFG_COLS:     cols_n = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] po, logic [31:0] to, logic [31:0] pi,
                            logic [31:0] ti, logic [31:0] nr, logic [31:0] nc);
        write_reg(CFG_P_ORIGIN, po);
        write_reg(CFG_T_ORIGIN, to);
        write_reg(CFG_P_INV, pi);
        write_reg(CFG_T_INV, ti);
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_COLS, nc);
    endtask

    function automatic in_item_t noise_item();
        logic [127:0] raw;
        in_item_t it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic logic [31:0] pick_coord(logic signed [31:0] o, logic [31:0] inv, int cnt);
        longint span;
        longint off;
        if (inv == 0) span = 64'hFFFFFFFF;
        else span = ((longint'(cnt - 1)) <<< 32) / longint'(inv);
        if (span > 64'hFFFFFFFF) span = 64'hFFFFFFFF;
        case ($urandom % 10)
            0: return $urandom;
            1: return o - $urandom_range(1, 300);
            2: off = span;
            3: off = (span > 2) ? span - 1 : 0;
            default: off = (longint'($urandom) << 32 | $urandom) % (span + 1);
        endcase
        return o + 32'(off);
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it = noise_item();
        if (($urandom % 100) < 12) begin
            it.op = OP_WRITE;
        end else begin
            it.op = op_t'($urandom_range(1, 3));
            it.pressure = pick_coord(p_org, p_inv, clamp_points(rows_n));
            it.temperature = pick_coord(t_org, t_inv, clamp_points(cols_n));
        end
        return it;
    endfunction

    function automatic logic [31:0] entry_pattern();
        case ($urandom % 6)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_table_load();
        in_item_t it;
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                it = noise_item();
                it.op = OP_WRITE;
                it.row_index = ROW_W'(r);
                it.col_index = COL_W'(c);
                it.entry_value = entry_pattern();
                send_item(it);
            end
        end
        drain();
    endtask

    task automatic test_directed();
        in_item_t it;
        logic [31:0] pts [8];
        pts = '{32'h0, 32'h000E_FFFF, 32'h000F_0000, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0007_8000, 32'h0000_0001};
        for (int k = 0; k < 8; k++) begin
            it = noise_item();
            it.op = op_t'(1 + k % 3);
            it.pressure = pts[k];
            it.temperature = pts[7 - k];
            send_item(it);
        end
        for (int k = 1; k < 4; k++) begin
            it = noise_item();
            it.op = op_t'(k);
            it.pressure = 32'h0003_4000;
            it.temperature = 32'h000E_C000;
            send_item(it);
        end
        it = noise_item();
        it.op = OP_WRITE;
        it.row_index = 4'hF;
        it.col_index = 4'hF;
        it.entry_value = 32'h8000_0000;
        send_item(it);
        it = noise_item();
        it.op = OP_SLOPE_T;
        it.pressure = 32'h000E_FFFF;
        it.temperature = 32'h000E_FFFF;
        send_item(it);
        drain();
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send_item(random_item());
        drain();
    endtask

    task automatic test_config_sweep();
        set_grid(32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0100, 2, 16);
        run_random(120);
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 0, 31);
        run_random(100);
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 17, 1);
        run_random(100);
        set_grid($urandom, $urandom, $urandom_range(1 << 12, 1 << 22),
                 $urandom_range(1 << 12, 1 << 22), $urandom_range(0, 31),
                 $urandom_range(0, 31));
        run_random(120);
        set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16, 16);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 300;
        for (int k = 0; k < 40; k++) send_item(random_item());
        drain();
        for (int k = 0; k < 20; k++) send_item(random_item());
        drain();
    endtask

    task automatic test_random_mix();
        send_idle_pct = 35;
        recv_idle_pct = 62;
        run_random(450);
        send_idle_pct = 62;
        recv_idle_pct = 35;
        run_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(450);
    endtask

    initial begin
        p_org = 0;
        t_org = 0;
        p_inv = 32'h0001_0000;
        t_inv = 32'h0001_0000;
        rows_n = 16;
        cols_n = 16;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_table_load();
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_mix();
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
